[rtl/core/ipde_pkg.sv]
// Shared types, constants and register codes of the IR pulse-distance encoder.
package ipde_pkg;

  localparam int unsigned MAX_BITS = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CNT_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARK_TIME       = 3'd0,
    REG_SPACE_ZERO      = 3'd1,
    REG_SPACE_ONE       = 3'd2,
    REG_GAP_TICKS       = 3'd3,
    REG_DATA_BITS       = 3'd4,
    REG_PREAMBLE_BITS   = 3'd5,
    REG_PREAMBLE_ENABLE = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PREA = 3'd1,
    PH_PREB = 3'd2,
    PH_BITA = 3'd3,
    PH_BITB = 3'd4,
    PH_STOP = 3'd5,
    PH_WAIT = 3'd6
  } phase_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  localparam logic [7:0]       RST_MARK_TIME       = 8'd20;
  localparam logic [7:0]       RST_SPACE_ZERO      = 8'd65;
  localparam logic [7:0]       RST_SPACE_ONE       = 8'd150;
  localparam logic [7:0]       RST_GAP_TICKS       = 8'd59;
  localparam logic [CNT_W-1:0] RST_DATA_BITS       = 6'd6;
  localparam logic [CNT_W-1:0] RST_PREAMBLE_BITS   = 6'd8;
  localparam logic             RST_PREAMBLE_ENABLE = 1'b0;

  typedef struct packed {
    logic [7:0]       mark_time;
    logic [7:0]       space_zero;
    logic [7:0]       space_one;
    logic [7:0]       gap_ticks;
    logic [CNT_W-1:0] data_bits;
    logic [CNT_W-1:0] preamble_bits;
    logic             preamble_enable;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [31:0] key_code;
    logic [7:0]  pre_word;
    logic [31:0] main_word;
  } in_item_t;

  typedef struct packed {
    logic       carrier_on;
    logic [7:0] interval;
    logic       idle;
    logic       accepted;
  } res_t;

  // Clamp a bit limit to 1..MAX_BITS.
  function automatic logic [CNT_W:0] eff_limit(input logic [CNT_W-1:0] lim);
    logic [CNT_W:0] l;
    l = {1'b0, lim};
    if (l == '0) begin
      l = (CNT_W+1)'(1);
    end
    if (l > (CNT_W+1)'(MAX_BITS)) begin
      l = (CNT_W+1)'(MAX_BITS);
    end
    return l;
  endfunction

endpackage

[rtl/core/ipde_if.sv]
// Valid/ready channel interfaces for start/tick items and interval results.
interface ipde_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] key_code;
  logic [7:0]  pre_word;
  logic [31:0] main_word;

  modport source (output valid, op, key_code, pre_word, main_word, input ready);
  modport sink (input valid, op, key_code, pre_word, main_word, output ready);
endinterface

interface ipde_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       carrier_on;
  logic [7:0] interval;
  logic       idle;
  logic       accepted;

  modport source (output valid, carrier_on, interval, idle, accepted, input ready);
  modport sink (input valid, carrier_on, interval, idle, accepted, output ready);
endinterface

[rtl/core/ir_pulse_distance_encoder_unit.sv]
// IR pulse-distance encoder top level: config registers, sequencer, result register.
// A result appears in the output register in the cycle after its item transfers.
// One item per cycle while the receiver takes each result; the sequencer state updates once per item.
// The input is ready whenever the output register is empty or being drained.
// Reset (synchronous, rst_n low): idle phase, counters and words cleared, held interval 20,
// configuration registers at their defaults, output register empty.
module ir_pulse_distance_encoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  ipde_in_if.sink                         in_chan,
  ipde_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [ipde_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ipde_pkg::CFG_DATA_W-1:0] cfg_data
);

  ipde_pkg::cfg_t     cfg;
  ipde_pkg::in_item_t item;
  ipde_pkg::res_t     res;
  ipde_pkg::res_t     res_r;
  logic               out_vld_r, out_vld_nxt;
  logic               in_fire;

  assign in_chan.ready = !out_vld_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign item.op        = in_chan.op;
  assign item.key_code  = in_chan.key_code;
  assign item.pre_word  = in_chan.pre_word;
  assign item.main_word = in_chan.main_word;

  ipde_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  ipde_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (in_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.carrier_on = res_r.carrier_on;
  assign out_chan.interval   = res_r.interval;
  assign out_chan.idle       = res_r.idle;
  assign out_chan.accepted   = res_r.accepted;

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_vld_r)
    else $error("transfer did not fill the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_chan.ready) |-> !in_fire)
    else $error("input transfer overwrote a pending result");

  a_accept_not_carrier: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.accepted) |-> (!res_r.carrier_on && !res_r.idle))
    else $error("accepted start shows carrier or idle");

endmodule

[rtl/core/ipde_cfg_regs.sv]
// Configuration register file of the IR pulse-distance encoder.
module ipde_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ipde_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ipde_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ipde_pkg::cfg_t                      cfg
);

  ipde_pkg::cfg_t cfg_r;
  ipde_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        ipde_pkg::REG_MARK_TIME:       cfg_nxt.mark_time = cfg_data;
        ipde_pkg::REG_SPACE_ZERO:      cfg_nxt.space_zero = cfg_data;
        ipde_pkg::REG_SPACE_ONE:       cfg_nxt.space_one = cfg_data;
        ipde_pkg::REG_GAP_TICKS:       cfg_nxt.gap_ticks = cfg_data;
        ipde_pkg::REG_DATA_BITS:       cfg_nxt.data_bits = cfg_data[ipde_pkg::CNT_W-1:0];
        ipde_pkg::REG_PREAMBLE_BITS:   cfg_nxt.preamble_bits = cfg_data[ipde_pkg::CNT_W-1:0];
        ipde_pkg::REG_PREAMBLE_ENABLE: cfg_nxt.preamble_enable = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_time       <= ipde_pkg::RST_MARK_TIME;
      cfg_r.space_zero      <= ipde_pkg::RST_SPACE_ZERO;
      cfg_r.space_one       <= ipde_pkg::RST_SPACE_ONE;
      cfg_r.gap_ticks       <= ipde_pkg::RST_GAP_TICKS;
      cfg_r.data_bits       <= ipde_pkg::RST_DATA_BITS;
      cfg_r.preamble_bits   <= ipde_pkg::RST_PREAMBLE_BITS;
      cfg_r.preamble_enable <= ipde_pkg::RST_PREAMBLE_ENABLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/ipde_engine.sv]
// Frame sequencer: phase, shift register, bit and gap counters, held interval.
module ipde_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ipde_pkg::in_item_t item,
  input  ipde_pkg::cfg_t     cfg,
  output ipde_pkg::res_t     res
);

  ipde_pkg::phase_t              phase_r, phase_nxt;
  logic [31:0]                   shift_r, shift_nxt;
  logic [ipde_pkg::CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                    gap_cnt_r, gap_cnt_nxt;
  logic [31:0]                   main_r, main_nxt;
  logic [7:0]                    ivl_r, ivl_nxt;

  logic                          start_ok;
  logic [ipde_pkg::CNT_W:0]      bit_inc;
  logic [ipde_pkg::CNT_W-1:0]    lim;
  logic                          word_done;
  logic [7:0]                    space_len;
  logic [7:0]                    gap_inc;

  assign start_ok  = (item.op == ipde_pkg::OP_START) && (item.key_code != 32'd0)
                     && (phase_r == ipde_pkg::PH_IDLE);
  assign bit_inc   = {1'b0, bit_cnt_r} + 7'd1;
  assign lim       = (phase_r == ipde_pkg::PH_PREB) ? cfg.preamble_bits : cfg.data_bits;
  assign word_done = bit_inc >= ipde_pkg::eff_limit(lim);
  assign space_len = shift_r[0] ? cfg.space_one : cfg.space_zero;
  assign gap_inc   = gap_cnt_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    shift_nxt   = shift_r;
    bit_cnt_nxt = bit_cnt_r;
    gap_cnt_nxt = gap_cnt_r;
    main_nxt    = main_r;
    ivl_nxt     = ivl_r;
    if (item.op == ipde_pkg::OP_START) begin
      if (start_ok) begin
        main_nxt    = item.main_word;
        bit_cnt_nxt = '0;
        gap_cnt_nxt = '0;
        if (cfg.preamble_enable) begin
          shift_nxt = {24'd0, item.pre_word};
          phase_nxt = ipde_pkg::PH_PREA;
        end else begin
          shift_nxt = item.key_code;
          phase_nxt = ipde_pkg::PH_BITA;
        end
      end
    end else begin
      case (phase_r)
        ipde_pkg::PH_PREA: begin
          ivl_nxt   = cfg.mark_time;
          phase_nxt = ipde_pkg::PH_PREB;
        end
        ipde_pkg::PH_BITA: begin
          ivl_nxt   = cfg.mark_time;
          phase_nxt = ipde_pkg::PH_BITB;
        end
        ipde_pkg::PH_STOP: begin
          ivl_nxt   = cfg.mark_time;
          phase_nxt = ipde_pkg::PH_WAIT;
        end
        ipde_pkg::PH_PREB: begin
          ivl_nxt     = space_len;
          shift_nxt   = shift_r >> 1;
          bit_cnt_nxt = bit_inc[ipde_pkg::CNT_W-1:0];
          if (word_done) begin
            phase_nxt   = ipde_pkg::PH_BITA;
            bit_cnt_nxt = '0;
            shift_nxt   = main_r;
          end else begin
            phase_nxt = ipde_pkg::PH_PREA;
          end
        end
        ipde_pkg::PH_BITB: begin
          ivl_nxt     = space_len;
          shift_nxt   = shift_r >> 1;
          bit_cnt_nxt = bit_inc[ipde_pkg::CNT_W-1:0];
          phase_nxt   = word_done ? ipde_pkg::PH_STOP : ipde_pkg::PH_BITA;
        end
        ipde_pkg::PH_WAIT: begin
          gap_cnt_nxt = gap_inc;
          if (gap_inc >= cfg.gap_ticks) begin
            bit_cnt_nxt = '0;
            gap_cnt_nxt = '0;
            phase_nxt   = ipde_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = ipde_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res.carrier_on = (item.op == ipde_pkg::OP_TICK) &&
                     ((phase_r == ipde_pkg::PH_PREA) || (phase_r == ipde_pkg::PH_BITA) ||
                      (phase_r == ipde_pkg::PH_STOP));
    res.interval   = ivl_nxt;
    res.idle       = (phase_nxt == ipde_pkg::PH_IDLE);
    res.accepted   = start_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ipde_pkg::PH_IDLE;
      shift_r   <= '0;
      bit_cnt_r <= '0;
      gap_cnt_r <= '0;
      main_r    <= '0;
      ivl_r     <= ipde_pkg::RST_MARK_TIME;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      shift_r   <= shift_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      gap_cnt_r <= gap_cnt_nxt;
      main_r    <= main_nxt;
      ivl_r     <= ivl_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.accepted) |=> (phase_r != ipde_pkg::PH_IDLE))
    else $error("accepted start left the sequencer idle");

  a_mark_loads_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.carrier_on) |=> (ivl_r == $past(cfg.mark_time)))
    else $error("carrier mark did not load mark_time");

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= ipde_pkg::CNT_W'(ipde_pkg::MAX_BITS))
    else $error("bit counter beyond word length");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ipde_pkg::PH_IDLE) |-> (gap_cnt_r == 8'd0))
    else $error("gap counter not clear while idle");

endmodule

[tb/pulse_frame_checker.sv]
// Frame checker for the IR pulse-distance encoder: predicts each interval result and compares.
`timescale 1ns / 1ps
module pulse_frame_checker
  import ipde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ipde_in_if                   in_mon,
  ipde_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   frames_begun,
  output int                   starts_refused
);

  cfg_t        regs;
  phase_t      ph;
  logic [31:0] shreg;
  logic [5:0]  bitn;
  logic [7:0]  gapn;
  logic [31:0] main_hold;
  logic [7:0]  iv_hold;

  res_t due_intervals[$];
  int   fails, seen, begun, refused;

  function automatic logic [6:0] bit_limit(input logic [5:0] n);
    if (n == 6'd0) return 7'd1;
    if (n > MAX_BITS) return 7'(MAX_BITS);
    return {1'b0, n};
  endfunction

  // Drive out the space of the current bit; true once the word is complete.
  function automatic logic emit_space(input logic [5:0] n);
    logic [6:0] cnt;
    iv_hold = shreg[0] ? regs.space_one : regs.space_zero;
    shreg = shreg >> 1;
    cnt = {1'b0, bitn} + 7'd1;
    bitn = cnt[5:0];
    return cnt >= bit_limit(n);
  endfunction

  function automatic res_t next_interval(input in_item_t it);
    res_t r;
    r = '0;
    if (it.op == OP_START) begin
      if (it.key_code != 32'd0 && ph == PH_IDLE) begin
        main_hold = it.main_word;
        bitn = '0;
        gapn = '0;
        if (regs.preamble_enable) begin
          shreg = {24'd0, it.pre_word};
          ph = PH_PREA;
        end else begin
          shreg = it.key_code;
          ph = PH_BITA;
        end
        r.accepted = 1'b1;
      end
    end else begin
      case (ph)
        PH_PREA, PH_BITA, PH_STOP: begin
          iv_hold = regs.mark_time;
          r.carrier_on = 1'b1;
          ph = phase_t'(ph + 3'd1);
        end
        PH_PREB: begin
          if (emit_space(regs.preamble_bits)) begin
            ph = PH_BITA;
            bitn = '0;
            shreg = main_hold;
          end else begin
            ph = PH_PREA;
          end
        end
        PH_BITB: begin
          ph = emit_space(regs.data_bits) ? PH_STOP : PH_BITA;
        end
        PH_WAIT: begin
          gapn = gapn + 8'd1;
          if (gapn >= regs.gap_ticks) begin
            bitn = '0;
            gapn = '0;
            ph = PH_IDLE;
          end
        end
        default: begin
          ph = PH_IDLE;
        end
      endcase
    end
    r.interval = iv_hold;
    r.idle = (ph == PH_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    in_item_t it;
    res_t     exp_r;
    res_t     got;
    if (!rst_n) begin
      regs = '{RST_MARK_TIME, RST_SPACE_ZERO, RST_SPACE_ONE, RST_GAP_TICKS,
               RST_DATA_BITS, RST_PREAMBLE_BITS, RST_PREAMBLE_ENABLE};
      ph = PH_IDLE;
      shreg = '0;
      bitn = '0;
      gapn = '0;
      main_hold = '0;
      iv_hold = RST_MARK_TIME;
      due_intervals.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_MARK_TIME:       regs.mark_time = cfg_data;
          REG_SPACE_ZERO:      regs.space_zero = cfg_data;
          REG_SPACE_ONE:       regs.space_one = cfg_data;
          REG_GAP_TICKS:       regs.gap_ticks = cfg_data;
          REG_DATA_BITS:       regs.data_bits = cfg_data[CNT_W-1:0];
          REG_PREAMBLE_BITS:   regs.preamble_bits = cfg_data[CNT_W-1:0];
          REG_PREAMBLE_ENABLE: regs.preamble_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.carrier_on, out_mon.interval, out_mon.idle, out_mon.accepted};
        seen++;
        if (due_intervals.size() == 0) begin
          $error("result transfer with no interval pending");
          fails++;
        end else begin
          exp_r = due_intervals.pop_front();
          if (got.carrier_on !== exp_r.carrier_on) begin
            $error("carrier_on: expected %0d, got %0d", exp_r.carrier_on, got.carrier_on);
            fails++;
          end
          if (got.interval !== exp_r.interval) begin
            $error("interval: expected %0d, got %0d", exp_r.interval, got.interval);
            fails++;
          end
          if (got.idle !== exp_r.idle) begin
            $error("idle: expected %0d, got %0d", exp_r.idle, got.idle);
            fails++;
          end
          if (got.accepted !== exp_r.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_r.accepted, got.accepted);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it = {in_mon.op, in_mon.key_code, in_mon.pre_word, in_mon.main_word};
        exp_r = next_interval(it);
        if (exp_r.accepted) begin
          begun++;
        end else if (it.op == OP_START) begin
          refused++;
        end
        due_intervals.push_back(exp_r);
      end
    end
    fail_count <= fails;
    pending <= due_intervals.size();
    results_seen <= seen;
    frames_begun <= begun;
    starts_refused <= refused;
  end

endmodule

[tb/testbench.sv]
// Testbench top: clock, reset, register settings, item traffic, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import ipde_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int WATCHDOG    = 4000;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending, results_seen, frames_begun, starts_refused;
  int tx_max, rx_max, settings_used;
  bit hold_req;

  ipde_in_if  in_chan (.clk(clk));
  ipde_out_if out_chan (.clk(clk));

  ir_pulse_distance_encoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  pulse_frame_checker frame_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .frames_begun   (frames_begun),
    .starts_refused (starts_refused)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_item(input op_t op, input logic [31:0] key, input logic [7:0] pre,
                           input logic [31:0] word_main);
    int n;
    n = $urandom_range(0, tx_max);
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.op        <= op;
    in_chan.key_code  <= key;
    in_chan.pre_word  <= pre;
    in_chan.main_word <= word_main;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_random();
    logic [31:0] key;
    key = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
    if ($urandom_range(0, 7) == 0) begin
      send_item(OP_START, key, 8'($urandom), $urandom);
    end else begin
      send_item(OP_TICK, $urandom, 8'($urandom), $urandom);
    end
  endtask

  // Drop valid and wait until every pending interval has come back.
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    cfg_we <= 1'b1;
    cfg_idx <= REG_MARK_TIME;
    cfg_data <= c.mark_time;
    @(posedge clk);
    cfg_idx <= REG_SPACE_ZERO;
    cfg_data <= c.space_zero;
    @(posedge clk);
    cfg_idx <= REG_SPACE_ONE;
    cfg_data <= c.space_one;
    @(posedge clk);
    cfg_idx <= REG_GAP_TICKS;
    cfg_data <= c.gap_ticks;
    @(posedge clk);
    cfg_idx <= REG_DATA_BITS;
    cfg_data <= {2'b00, c.data_bits};
    @(posedge clk);
    cfg_idx <= REG_PREAMBLE_BITS;
    cfg_data <= {2'b00, c.preamble_bits};
    @(posedge clk);
    cfg_idx <= REG_PREAMBLE_ENABLE;
    cfg_data <= {7'd0, c.preamble_enable};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_t rand_settings();
    cfg_t c;
    c.mark_time       = 8'($urandom);
    c.space_zero      = 8'($urandom);
    c.space_one       = 8'($urandom);
    c.gap_ticks       = 8'($urandom_range(0, 20));
    c.data_bits       = 6'($urandom_range(1, 12));
    c.preamble_bits   = 6'($urandom_range(1, 10));
    c.preamble_enable = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin
    int n;
    out_chan.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      n = $urandom_range(0, rx_max);
      if (n > 0) begin
        out_chan.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!(out_chan.valid && out_chan.ready)) @(posedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_t plan[5];
    int   n;
    plan[0] = '{8'd0, 8'd0, 8'd255, 8'd0, 6'd1, 6'd1, 1'b1};
    plan[1] = '{8'd255, 8'd255, 8'd0, 8'd255, 6'd32, 6'd32, 1'b1};
    plan[2] = '{8'd7, 8'd14, 8'd28, 8'd3, 6'd0, 6'd0, 1'b1};
    plan[3] = '{8'd170, 8'd1, 8'd2, 8'd1, 6'd63, 6'd40, 1'b0};
    plan[4] = '{8'd14, 8'd170, 8'd7, 8'd5, 6'd32, 6'd1, 1'b0};
    tx_max = 0;
    rx_max = 17;
    hold_req = 1'b0;
    settings_used = 1;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_MARK_TIME;
    cfg_data <= '0;
    in_chan.valid <= 1'b0;
    in_chan.op <= OP_TICK;
    in_chan.key_code <= '0;
    in_chan.pre_word <= '0;
    in_chan.main_word <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: tick while idle, refused starts, an all-ones frame.
    send_item(OP_TICK, 32'd0, 8'd0, 32'd0);
    send_item(OP_START, 32'd0, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_START, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_START, 32'd1, 8'd0, 32'd0);
    repeat (14) send_item(OP_TICK, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_START, 32'h8000_0000, 8'd0, 32'd0);
    repeat (5) send_item(OP_TICK, 32'd0, 8'd0, 32'd0);

    tx_max = 17;
    for (int i = 0; i < 260; i++) begin
      if (i == 80) hold_req = 1'b1;
      if (i == 160) settle();
      send_random();
    end

    for (int p = 0; p < 7; p++) begin
      settle();
      tx_max = (p % 3 == 1) ? 0 : 17;
      rx_max = (p % 3 == 2) ? 0 : 17;
      load_settings(p < 5 ? plan[p] : rand_settings());
      n = (p == 1) ? 450 : 200;
      for (int i = 0; i < n; i++) begin
        if (p == 0 && i == 100) hold_req = 1'b1;
        if (p == 2 && i == 100) settle();
        send_random();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Run covered %0d results under %0d register settings.", results_seen,
             settings_used);
    $display("Frames begun: %0d, start requests refused: %0d.", frames_begun, starts_refused);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ipde_pkg.sv
rtl/core/ipde_if.sv
rtl/core/ipde_cfg_regs.sv
rtl/core/ipde_engine.sv
rtl/core/ir_pulse_distance_encoder_unit.sv
tb/pulse_frame_checker.sv
tb/testbench.sv
